[rtl/dda_pkg.sv]
// Package: constants, types and state encoding for the grid raycaster.
`timescale 1ns / 1ps
`default_nettype none
package dda_pkg;
  localparam int MAP_SIZE_D  = 64;
  localparam int TEX_WIDTH_D = 64;
  localparam int MAX_STEPS_D = 128;
  localparam int FRAC_BITS_D = 16;

  localparam logic [7:0] EMPTY_CODE = 8'd48;

  localparam logic [2:0] REG_POS_X   = 3'd0;
  localparam logic [2:0] REG_POS_Y   = 3'd1;
  localparam logic [2:0] REG_DIR_X   = 3'd2;
  localparam logic [2:0] REG_DIR_Y   = 3'd3;
  localparam logic [2:0] REG_PLANE_X = 3'd4;
  localparam logic [2:0] REG_PLANE_Y = 3'd5;
  localparam logic [2:0] REG_SCR_W   = 3'd6;
  localparam logic [2:0] REG_SCR_H   = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAM_DIV,
    ST_RAY,
    ST_DX_DIV,
    ST_DY_DIV,
    ST_SIDE,
    ST_STEP,
    ST_CHECK,
    ST_LH_DIV,
    ST_TEX,
    ST_DONE
  } dda_state_t;

  // Divider control handed between the sequencer and the divider.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } dda_div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quot;
  } dda_div_rsp_t;
endpackage
`default_nettype wire

[rtl/dda_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module dda_div
  import dda_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire dda_div_req_t req,
  output dda_div_rsp_t      rsp
);
  logic [63:0] rem_r, rem_nxt, quo_r, quo_nxt, den_r, den_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [64:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[63]} - {1'b0, den_r};
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.num;
      den_nxt  = req.den;
      cnt_nxt  = 7'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in one numerator bit, keep the difference when it fits
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[62:0], quo_r[63]};
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
endmodule
`default_nettype wire

[rtl/dda_wall_raycaster.sv]
// Top level: fixed-point DDA grid raycaster with on-chip map memory.
// Usage:
//   The input channel (in_valid/in_ready) carries one word per item. A word
//   with in_action low stores in_cell_value at (in_cell_x, in_cell_y) in the
//   map memory and gives no result. A word with in_action high casts a ray
//   for in_column and gives one result word on the out_ channel.
//   The configuration port writes viewer position, direction, camera plane
//   and screen size; write it only while the block is idle.
// Sequencing:
//   A map write is stored when its word is accepted. A cast uses the
//   shared 64-step serial divider (camera mapping, two delta distances and
//   the line height), and each grid step goes through the map memory
//   (address, then registered read data), up to MAX_STEPS steps. One item
//   is in flight at a time.
// Reset:
//   Synchronous active-low reset restores the register defaults and idles
//   the sequencer. The map memory is not cleared: cells read before they
//   are written give undefined codes.
// Stall:
//   The result is held in the output register until out_ready; the next
//   word is accepted meanwhile, and a cast waits only at its final hand-off.
`timescale 1ns / 1ps
`default_nettype none
module dda_wall_raycaster
  import dda_pkg::*;
#(
  parameter int MAP_SIZE  = MAP_SIZE_D,
  parameter int MAX_STEPS = MAX_STEPS_D
)(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [21:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic [9:0]  in_column,
  input  wire logic [5:0]  in_cell_x,
  input  wire logic [5:0]  in_cell_y,
  input  wire logic [7:0]  in_cell_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [9:0]       out_column,
  output logic [23:0]      out_perp_dist,
  output logic             out_hit_side,
  output logic [7:0]       out_hit_cell,
  output logic [5:0]       out_tex_column,
  output logic [10:0]      out_draw_start,
  output logic [10:0]      out_draw_end,
  output logic             out_no_hit
);
  localparam int F  = FRAC_BITS_D;
  localparam int MB = $clog2(MAP_SIZE);
  localparam int SB = $clog2(MAX_STEPS + 1);
  localparam int TB = $clog2(TEX_WIDTH_D);
  localparam int MEM_DEPTH = 1 << (2 * MB);
  localparam logic [36:0] DELTA_SAT = 37'(64'd1 << 36);
  localparam logic [63:0] ONE_SQ    = 64'd1 << (2 * F);

  // configuration registers
  logic [21:0] pos_x_r, pos_y_r;
  logic signed [17:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;
  logic [10:0] scr_w_r, scr_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0; pos_y_r <= '0;
      dir_x_r <= '0; dir_y_r <= '0; plane_x_r <= '0; plane_y_r <= '0;
      scr_w_r <= 11'd720; scr_h_r <= 11'd480;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POS_X:   pos_x_r   <= cfg_data;
        REG_POS_Y:   pos_y_r   <= cfg_data;
        REG_DIR_X:   dir_x_r   <= cfg_data[17:0];
        REG_DIR_Y:   dir_y_r   <= cfg_data[17:0];
        REG_PLANE_X: plane_x_r <= cfg_data[17:0];
        REG_PLANE_Y: plane_y_r <= cfg_data[17:0];
        REG_SCR_W:   scr_w_r   <= cfg_data[10:0];
        REG_SCR_H:   scr_h_r   <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // map memory: one write port, one registered read port
  logic [7:0]      map_mem [MEM_DEPTH];
  logic [2*MB-1:0] rd_addr;
  logic [7:0]      rd_data_r;
  logic            wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) map_mem[{MB'(in_cell_y), MB'(in_cell_x)}] <= in_cell_value;
    rd_data_r <= map_mem[rd_addr];
  end

  // shared divider
  dda_div_req_t div_req;
  dda_div_rsp_t div_rsp;
  dda_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  dda_state_t state_r, state_nxt;
  logic        busy_started_r, busy_started_nxt;
  logic [9:0]  col_r;
  logic signed [28:0] cam_r;
  logic signed [31:0] rx_r, ry_r;
  logic [36:0] dx_r, dy_r;
  logic [43:0] sx_r, sy_r;
  logic signed [8:0] mx_r, my_r;
  logic        side_r;
  logic [SB-1:0] n_r;
  logic        hit_r;
  logic [7:0]  cell_r;
  logic [23:0] perp_r;
  logic [10:0] lh_r;
  logic [5:0]  tex_r;

  // output register
  logic        ov_r;
  logic [9:0]  o_col_r;
  logic [23:0] o_perp_r;
  logic        o_side_r, o_nohit_r;
  logic [7:0]  o_cell_r;
  logic [5:0]  o_tex_r;
  logic [10:0] o_ds_r, o_de_r;

  wire in_fire = in_valid && in_ready;

  // datapath helpers
  logic [10:0] w_eff;
  logic signed [46:0] pcx, pcy;
  logic signed [31:0] rxc, ryc;
  logic [36:0] dq_sat;
  logic [F:0]  fx_c, fy_c, ax, ay;
  logic [53:0] sxp, syp;
  logic signed [8:0] mx_n, my_n;
  logic        out_grid;
  logic [43:0] perp_raw;
  logic signed [56:0] wprod;
  logic signed [56:0] wsh;
  logic signed [57:0] wall;
  logic [F+TB-1:0] texp;
  logic [TB-1:0] tex_raw;
  logic [10:0] lh_c, ds_c;
  logic [11:0] de_c;

  assign w_eff = (scr_w_r == 11'd0) ? 11'd1 : scr_w_r;
  assign pcx = plane_x_r * cam_r;
  assign pcy = plane_y_r * cam_r;
  assign rxc = 32'(dir_x_r) + 32'(pcx >>> F);
  assign ryc = 32'(dir_y_r) + 32'(pcy >>> F);
  assign dq_sat = (div_rsp.quot > 64'(DELTA_SAT)) ? DELTA_SAT : div_rsp.quot[36:0];
  assign fx_c = {1'b0, pos_x_r[F-1:0]};
  assign fy_c = {1'b0, pos_y_r[F-1:0]};
  assign ax = rx_r[31] ? fx_c : (17'(1) << F) - fx_c;
  assign ay = ry_r[31] ? fy_c : (17'(1) << F) - fy_c;
  assign sxp = ax * dx_r;
  assign syp = ay * dy_r;
  assign mx_n = (sx_r < sy_r) ? (rx_r[31] ? mx_r - 9'sd1 : mx_r + 9'sd1) : mx_r;
  assign my_n = (sx_r < sy_r) ? my_r : (ry_r[31] ? my_r - 9'sd1 : my_r + 9'sd1);
  assign out_grid = mx_n < 0 || my_n < 0 || int'(mx_n) >= MAP_SIZE || int'(my_n) >= MAP_SIZE;
  assign perp_raw = side_r ? sy_r - 44'(dy_r) : sx_r - 44'(dx_r);
  assign wprod = $signed({1'b0, perp_r}) * (side_r ? rx_r : ry_r);
  assign wsh = wprod >>> F;
  assign wall = $signed({36'd0, side_r ? pos_x_r : pos_y_r}) + 58'(wsh);
  assign texp = wall[F-1:0] * (F+TB)'(TEX_WIDTH_D);
  assign tex_raw = texp[F+TB-1:F];
  assign lh_c = (perp_r == 24'd0 || div_rsp.quot > 64'(scr_h_r)) ? scr_h_r
              : div_rsp.quot[10:0];
  assign ds_c = (scr_h_r >> 1) - (lh_r >> 1);
  assign de_c = {1'b0, ds_c} + {1'b0, lh_r};

  always_comb begin
    state_nxt = state_r;
    busy_started_nxt = busy_started_r;
    unique case (state_r)
      ST_IDLE:    if (in_fire && in_action) state_nxt = ST_CAM_DIV;
      ST_CAM_DIV: if (div_rsp.done) state_nxt = ST_RAY;
      ST_RAY:     state_nxt = ST_DX_DIV;
      ST_DX_DIV:  if (div_rsp.done || (!busy_started_r && rx_r == 0)) state_nxt = ST_DY_DIV;
      ST_DY_DIV:  if (div_rsp.done || (!busy_started_r && ry_r == 0)) state_nxt = ST_SIDE;
      ST_SIDE:    state_nxt = ST_STEP;
      ST_STEP:    state_nxt = out_grid ? ST_LH_DIV : ST_CHECK;
      ST_CHECK: begin
        if (rd_data_r != EMPTY_CODE || n_r == SB'(MAX_STEPS)) state_nxt = ST_LH_DIV;
        else state_nxt = ST_STEP;
      end
      ST_LH_DIV:  if (!hit_r || perp_r == 0 || div_rsp.done) state_nxt = ST_TEX;
      ST_TEX:     state_nxt = ST_DONE;
      ST_DONE:    if (!ov_r || out_ready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
    if (state_nxt != state_r) busy_started_nxt = 1'b0;
    else if (div_req.start) busy_started_nxt = 1'b1;
  end

  always_comb begin
    in_ready = (state_r == ST_IDLE);
    wr_en    = in_fire && !in_action && int'(in_cell_x) < MAP_SIZE
               && int'(in_cell_y) < MAP_SIZE;
    rd_addr  = {my_n[MB-1:0], mx_n[MB-1:0]};
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = 64'd1;
    unique case (state_r)
      ST_IDLE: begin
        div_req.start = in_fire && in_action;
        div_req.num   = 64'({in_column, 1'b0}) << F;
        div_req.den   = 64'(w_eff);
      end
      ST_DX_DIV: begin
        div_req.start = !busy_started_r && rx_r != 0;
        div_req.num   = ONE_SQ;
        div_req.den   = 64'(rx_r[31] ? -rx_r : rx_r);
      end
      ST_DY_DIV: begin
        div_req.start = !busy_started_r && ry_r != 0;
        div_req.num   = ONE_SQ;
        div_req.den   = 64'(ry_r[31] ? -ry_r : ry_r);
      end
      ST_LH_DIV: begin
        div_req.start = !busy_started_r && hit_r && perp_r != 0;
        div_req.num   = 64'(scr_h_r) << F;
        div_req.den   = 64'(perp_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_started_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_started_r <= busy_started_nxt;
      if (state_r == ST_DONE && state_nxt == ST_IDLE) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
    unique case (state_r)
      ST_IDLE: if (in_fire) col_r <= in_column;
      ST_CAM_DIV: if (div_rsp.done) cam_r <= 29'(div_rsp.quot) - 29'(1 << F);
      ST_RAY: begin
        rx_r <= rxc; ry_r <= ryc;
      end
      ST_DX_DIV: begin
        if (!busy_started_r && rx_r == 0) dx_r <= DELTA_SAT;
        else if (div_rsp.done) dx_r <= dq_sat;
      end
      ST_DY_DIV: begin
        if (!busy_started_r && ry_r == 0) dy_r <= DELTA_SAT;
        else if (div_rsp.done) dy_r <= dq_sat;
      end
      ST_SIDE: begin
        sx_r <= 44'(sxp >> F);
        sy_r <= 44'(syp >> F);
        mx_r <= 9'(pos_x_r[21:F]);
        my_r <= 9'(pos_y_r[21:F]);
        n_r  <= '0;
        hit_r <= 1'b0;
      end
      ST_STEP: begin
        // advance one cell along the nearer side
        if (sx_r < sy_r) begin
          sx_r <= sx_r + 44'(dx_r); side_r <= 1'b0;
        end else begin
          sy_r <= sy_r + 44'(dy_r); side_r <= 1'b1;
        end
        mx_r <= mx_n; my_r <= my_n;
        n_r  <= n_r + SB'(1);
      end
      ST_CHECK: begin
        cell_r <= rd_data_r;
        if (rd_data_r != EMPTY_CODE) begin
          hit_r  <= 1'b1;
          perp_r <= (perp_raw > 44'hFFFFFF) ? 24'hFFFFFF : perp_raw[23:0];
        end
      end
      ST_LH_DIV: lh_r <= lh_c;
      ST_TEX: begin
        if ((!side_r && !rx_r[31] && rx_r != 0) || (side_r && ry_r[31]))
          tex_r <= 6'(TB'(TEX_WIDTH_D - 1) - tex_raw);
        else
          tex_r <= 6'(tex_raw);
      end
      ST_DONE: if (!ov_r || out_ready) begin
        o_col_r   <= col_r;
        o_nohit_r <= !hit_r;
        o_perp_r  <= hit_r ? perp_r : '0;
        o_side_r  <= hit_r && side_r;
        o_cell_r  <= hit_r ? cell_r : '0;
        o_tex_r   <= hit_r ? tex_r : '0;
        o_ds_r    <= hit_r ? ds_c : '0;
        o_de_r    <= hit_r ? ((de_c > 12'(scr_h_r)) ? scr_h_r : de_c[10:0]) : '0;
      end
      default: ;
    endcase
  end

  assign out_valid      = ov_r;
  assign out_column     = o_col_r;
  assign out_perp_dist  = o_perp_r;
  assign out_hit_side   = o_side_r;
  assign out_hit_cell   = o_cell_r;
  assign out_tex_column = o_tex_r;
  assign out_draw_start = o_ds_r;
  assign out_draw_end   = o_de_r;
  assign out_no_hit     = o_nohit_r;
endmodule
`default_nettype wire
